[hw/rtl/icsr_pkg.sv]
package icsr_pkg;

  localparam int unsigned TH_W            = 50;
  localparam int unsigned TL_W            = 64;
  localparam int unsigned T_W             = TH_W + TL_W;
  localparam int unsigned ROOT_W          = 58;
  localparam int unsigned CNT_W           = 6;
  localparam int unsigned STAT_W          = 2;
  localparam int unsigned GRP_W           = 8;
  localparam int unsigned TARGET_BITS_DEF = 114;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_FAIL = 2'd2
  } status_e;

  // leading-pair search result: k is half the target bit length, rounded up
  typedef struct packed {
    logic             done;
    logic             zero;
    logic [CNT_W-1:0] k;
  } lead_res_t;

endpackage

[hw/rtl/integer_ceiling_square_root.sv]
// A target is taken while idle; a leading-pair search (S_LEAD0, S_LEADW) then finds
// k = ceil(bitlen(target) / 2), and a zero target finishes there with no bisection steps.
// One shared add/compare unit then does one bisection step per cycle in S_STEP, k steps
// in all, followed by the S_CHK1 and S_CHK2 checks; results wait while the output is held.
// in_ready_o is high only while idle, so a new target is taken only once the last one is done.
// Reset is asynchronous, active low, and clears the sequencer and the output valid.
module integer_ceiling_square_root #(
  parameter int unsigned TARGET_BITS = icsr_pkg::TARGET_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [icsr_pkg::TH_W-1:0]     target_high_i,
  input  logic [icsr_pkg::TL_W-1:0]     target_low_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [icsr_pkg::ROOT_W-1:0]   root_o,
  output logic [icsr_pkg::CNT_W-1:0]    step_count_o,
  output logic [icsr_pkg::STAT_W-1:0]  status_o
);

  localparam int unsigned TW  = icsr_pkg::T_W;
  localparam int unsigned KW  = (TARGET_BITS + 1) / 2;
  localparam int unsigned SQW = 2 * KW;
  localparam int unsigned OPW = (SQW > TW) ? SQW : TW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAD0,
    S_LEADW,
    S_STEP,
    S_CHK1,
    S_CHK2
  } state_e;

  state_e                        state_q;
  logic [TW-1:0]                 target_m;
  logic [TW-1:0]                 target_q;
  logic [KW-1:0]                 lo_q;
  logic [KW-1:0]                 pj_q;
  logic [KW-1:0]                 pj_init;
  logic [SQW-1:0]                losq_q;
  logic [SQW-1:0]                lsh_q;
  logic [SQW-1:0]                bitq_q;
  logic [SQW-1:0]                bit_init;
  logic [SQW-1:0]                msq;
  logic [icsr_pkg::CNT_W-1:0]    cnt_q;
  logic [icsr_pkg::CNT_W-1:0]    k_q;
  logic                          fail_q;
  logic                          out_valid_q;
  logic                          out_free;
  logic                          out_set;
  logic [icsr_pkg::ROOT_W-1:0]   root_q;
  logic [icsr_pkg::CNT_W-1:0]    count_q;
  icsr_pkg::status_e             status_q;
  logic [KW:0]                   root_full;
  logic [OPW-1:0]                alu_a;
  logic [OPW-1:0]                alu_b;
  logic [OPW:0]                  alu_sum;
  logic                          alu_ge;
  icsr_pkg::lead_res_t           lead_res;

  function automatic logic [icsr_pkg::TL_W-1:0] TL_MASK();
    logic [icsr_pkg::TL_W-1:0] m;
    for (int i = 0; i < icsr_pkg::TL_W; i++) m[i] = (i < TARGET_BITS);
    return m;
  endfunction

  function automatic logic [icsr_pkg::TH_W-1:0] TH_MASK();
    logic [icsr_pkg::TH_W-1:0] m;
    for (int i = 0; i < icsr_pkg::TH_W; i++) m[i] = (i + icsr_pkg::TL_W < TARGET_BITS);
    return m;
  endfunction

  always_comb begin
    target_m[icsr_pkg::TL_W-1:0]  = target_low_i & TL_MASK();
    target_m[TW-1:icsr_pkg::TL_W] = target_high_i & TH_MASK();
  end

  icsr_lead #(
    .RootW (KW)
  ) u_lead (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == S_LEAD0),
    .target_i (target_q),
    .res_o    (lead_res)
  );

  // one-hot start points: bitq = 2^(2j), pj = 2^j with j = k-1
  always_comb begin
    for (int i = 0; i < SQW; i++) begin
      bit_init[i] = (i == 2 * (int'(lead_res.k) - 1));
    end
    for (int i = 0; i < KW; i++) begin
      pj_init[i] = (i == int'(lead_res.k) - 1);
    end
  end

  // step: mid^2 = (lo^2 | 2^(2j)) + (lo << (j+1)); check: hi^2 = lo^2 + (2lo + 1)
  always_comb begin
    unique case (state_q)
      S_STEP: begin
        alu_a = OPW'(losq_q | bitq_q);
        alu_b = OPW'(lsh_q);
      end
      S_CHK1: begin
        alu_a = OPW'(losq_q);
        alu_b = OPW'({lo_q, 1'b1});
      end
      default: begin
        alu_a = OPW'(losq_q);
        alu_b = '0;
      end
    endcase
  end

  icsr_alu #(
    .OpW (OPW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .c_i   (OPW'(target_q)),
    .sum_o (alu_sum),
    .ge_o  (alu_ge)
  );

  assign msq       = alu_sum[SQW-1:0];
  assign out_free  = !out_valid_q || out_ready_i;
  assign root_full = (KW+1)'(lo_q) + (KW+1)'(1);
  assign out_set   = out_free && (((state_q == S_LEADW) && lead_res.done && lead_res.zero)
                                  || (state_q == S_CHK2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      target_q    <= '0;
      lo_q        <= '0;
      pj_q        <= '0;
      losq_q      <= '0;
      lsh_q       <= '0;
      bitq_q      <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
      root_q      <= '0;
      count_q     <= '0;
      status_q    <= icsr_pkg::STAT_OK;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            target_q <= target_m;
            state_q  <= S_LEAD0;
          end
        end
        S_LEAD0: begin
          state_q <= S_LEADW;
        end
        S_LEADW: begin
          if (lead_res.done) begin
            if (lead_res.zero) begin
              if (out_free) begin
                root_q      <= '0;
                count_q     <= '0;
                status_q    <= icsr_pkg::STAT_ZERO;
                state_q     <= S_IDLE;
              end
            end else begin
              k_q     <= lead_res.k;
              cnt_q   <= lead_res.k;
              lo_q    <= '0;
              losq_q  <= '0;
              lsh_q   <= '0;
              bitq_q  <= bit_init;
              pj_q    <= pj_init;
              state_q <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (alu_ge) begin
            lsh_q <= lsh_q >> 1;
          end else begin
            losq_q <= msq;
            lsh_q  <= (lsh_q >> 1) | bitq_q;
            lo_q   <= lo_q | pj_q;
          end
          bitq_q <= bitq_q >> 2;
          pj_q   <= pj_q >> 1;
          cnt_q  <= cnt_q - icsr_pkg::CNT_W'(1);
          if (cnt_q == icsr_pkg::CNT_W'(1)) state_q <= S_CHK1;
        end
        S_CHK1: begin
          fail_q  <= !alu_ge;
          state_q <= S_CHK2;
        end
        S_CHK2: begin
          if (out_free) begin
            root_q      <= icsr_pkg::ROOT_W'(root_full);
            count_q     <= k_q;
            status_q    <= (fail_q || alu_ge) ? icsr_pkg::STAT_FAIL : icsr_pkg::STAT_OK;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign root_o       = root_q;
  assign step_count_o = count_q;
  assign status_o     = status_q;

endmodule

[hw/rtl/icsr_alu.sv]
module icsr_alu #(
  parameter int unsigned OpW = 116
) (
  input  logic [OpW-1:0] a_i,
  input  logic [OpW-1:0] b_i,
  input  logic [OpW-1:0] c_i,
  output logic [OpW:0]   sum_o,
  output logic           ge_o
);

  assign sum_o = {1'b0, a_i} + {1'b0, b_i};
  assign ge_o  = sum_o >= {1'b0, c_i};

endmodule

[hw/rtl/icsr_lead.sv]
module icsr_lead #(
  parameter int unsigned RootW = 57
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [icsr_pkg::T_W-1:0] target_i,
  output icsr_pkg::lead_res_t      res_o
);

  localparam int unsigned G   = icsr_pkg::GRP_W;
  localparam int unsigned NG  = (RootW + G - 1) / G;
  localparam int unsigned GIW = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned PW  = NG * G;
  localparam int unsigned TPW = 2 * PW;
  localparam int unsigned IW  = $clog2(G);

  logic [TPW-1:0] tpad;
  logic [PW-1:0]  pair;
  logic [PW-1:0]  pair_q;
  logic [NG-1:0]  grp;
  logic [NG-1:0]  grp_q;
  logic [GIW-1:0] g_sel;
  logic [GIW-1:0] g_q;
  logic           any_q;
  logic           v1_q;
  logic           v2_q;
  logic [G-1:0]   gbits;
  logic [IW-1:0]  idx;

  // pair i is nonzero when target bits 2i+1:2i hold a one
  always_comb begin
    tpad = TPW'(target_i);
    for (int i = 0; i < PW; i++) begin
      pair[i] = tpad[2*i] | tpad[2*i+1];
    end
    for (int g = 0; g < NG; g++) begin
      grp[g] = |pair[g*G +: G];
    end
  end

  always_comb begin
    g_sel = '0;
    for (int i = 0; i < NG; i++) begin
      if (grp_q[i]) g_sel = GIW'(i);
    end
  end

  always_comb begin
    gbits = pair_q[int'(g_q)*G +: G];
    idx   = '0;
    for (int i = 0; i < G; i++) begin
      if (gbits[i]) idx = IW'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      pair_q <= '0;
      grp_q  <= '0;
      g_q    <= '0;
      any_q  <= 1'b0;
    end else begin
      v1_q <= start_i;
      if (start_i) begin
        pair_q <= pair;
        grp_q  <= grp;
        v2_q   <= 1'b0;
      end
      if (v1_q) begin
        g_q   <= g_sel;
        any_q <= |grp_q;
        v2_q  <= 1'b1;
      end
    end
  end

  assign res_o.done = v2_q;
  assign res_o.zero = !any_q;
  assign res_o.k    = icsr_pkg::CNT_W'({g_q, idx}) + icsr_pkg::CNT_W'(1);

endmodule

[hw/rtl/icsr_checker.sv]
module icsr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [icsr_pkg::TH_W-1:0]     target_high_i,
  input logic [icsr_pkg::TL_W-1:0]     target_low_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [icsr_pkg::ROOT_W-1:0]   root_o,
  input logic [icsr_pkg::CNT_W-1:0]    step_count_o,
  input logic [icsr_pkg::STAT_W-1:0]   status_o
);

  // in_ready_o drops once the block takes a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready high right after input transaction");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == icsr_pkg::STAT_ZERO |-> root_o == '0 && step_count_o == '0)
    else $error("zero target with nonzero root or count");

  a_ok_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == icsr_pkg::STAT_OK |-> root_o != '0 && step_count_o != '0)
    else $error("ok status with zero root or count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(root_o) && $stable(status_o)
      && $stable(step_count_o))
    else $error("stalled result changed");

endmodule

bind integer_ceiling_square_root icsr_checker u_icsr_checker (.*);
